// ===== rtl/core/tnu_pkg.sv =====
// Shared constants, codes and types of the triangle normal unit.
`default_nettype none
package tnu_pkg;

  localparam int VERTEX_COUNT   = 1024;
  localparam int TRIANGLE_COUNT = 1024;
  localparam int VADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int TADDR_W = (TRIANGLE_COUNT > 1) ? $clog2(TRIANGLE_COUNT) : 1;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;
  localparam int EDGE_W  = 33;
  localparam int CROSS_W = 67;
  localparam int MAG_W   = 67;
  localparam int LO_W    = 34;
  localparam int SUM_W   = 134;
  localparam int ROOT_W  = 67;
  localparam int REM_W   = 70;
  localparam int CS_W    = 79;
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 70;
  localparam int NRM_W   = 12;
  localparam int Q_W     = 11;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    MODE_WR_VTX  = 2'd0,
    MODE_WR_TRI  = 2'd1,
    MODE_TRI_NRM = 2'd2,
    MODE_VTX_NRM = 2'd3
  } tnu_mode_t;

  typedef struct packed {
    logic                   vtx_we;
    logic [VADDR_W-1:0]     vtx_waddr;
    logic [3*COORD_W-1:0]   vtx_wdata;
    logic                   tri_we;
    logic [TADDR_W-1:0]     tri_waddr;
    logic [3*IDX_W-1:0]     tri_wdata;
    logic [VADDR_W-1:0]     vtx_raddr;
    logic [TADDR_W-1:0]     tri_raddr;
  } tnu_store_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/tnu_in_if.sv =====
// Input item channel of the triangle normal unit.
`default_nettype none
interface tnu_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [tnu_pkg::IDX_W-1:0]           slot;
  logic signed [tnu_pkg::COORD_W-1:0]  coord_x;
  logic signed [tnu_pkg::COORD_W-1:0]  coord_y;
  logic signed [tnu_pkg::COORD_W-1:0]  coord_z;
  logic [tnu_pkg::IDX_W-1:0]           vert_a;
  logic [tnu_pkg::IDX_W-1:0]           vert_b;
  logic [tnu_pkg::IDX_W-1:0]           vert_c;

  modport source (output valid, mode, slot, coord_x, coord_y, coord_z, vert_a, vert_b, vert_c,
                  input ready);
  modport sink (input valid, mode, slot, coord_x, coord_y, coord_z, vert_a, vert_b, vert_c,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tnu_out_if.sv =====
// Result item channel of the triangle normal unit.
`default_nettype none
interface tnu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tnu_pkg::NRM_W-1:0]   normal_x;
  logic signed [tnu_pkg::NRM_W-1:0]   normal_y;
  logic signed [tnu_pkg::NRM_W-1:0]   normal_z;
  logic                               degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/triangle_normal_unit_core.sv =====
// Top level of the triangle normal unit: sequencer, datapath and result register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------------
//  in_ch   | in  | valid / ready | mode, slot, coord_x/y/z, vert_a/b/c
//  out_ch  | out | valid / ready | normal_x/y/z, degenerate
//
// Write items (vertex, triangle) give no result and leave the sequencer idle.
// A normal item keeps the input closed until its result enters the output register:
// vertex reads, edge, 7 cross steps and 10 square steps (15 products on the
// shared multiplier), magnitude, 67 root bit pairs on the shared compare-subtract
// unit, three divisions (load plus 11 steps each) and the result state.
// A stored triangle first reads its indices; a zero cross product skips root and
// divisions; a triangle slot out of range goes straight to the result state.
// Reset (rst_n low, synchronous) clears the sequencer and the result valid;
// the memories are not cleared. A finished result waits in the output
// register; the block takes new items meanwhile and only holds at the end
// of the next normal until that register is free.
`default_nettype none
module triangle_normal_unit_core (
  input  logic       clk,
  input  logic       rst_n,
  tnu_in_if.sink     in_ch,
  tnu_out_if.source  out_ch
);
  import tnu_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_TRI   = 11'b000_0000_0010,
    S_VRD   = 11'b000_0000_0100,
    S_EDGE  = 11'b000_0000_1000,
    S_CROSS = 11'b000_0001_0000,
    S_MAG   = 11'b000_0010_0000,
    S_SQ    = 11'b000_0100_0000,
    S_SQRT  = 11'b000_1000_0000,
    S_DLOAD = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  localparam logic [CNT_W-1:0] VRD_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] CROSS_LAST = CNT_W'(6);
  localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(9);
  localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(Q_W - 1);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [1:0]                comp_r, comp_nxt;

  // datapath
  logic [IDX_W-1:0]          idx_r   [3];
  logic signed [COORD_W-1:0] pt_r    [3][3];
  logic                      oob_d_r;
  logic signed [EDGE_W-1:0]  e1_r    [3];
  logic signed [EDGE_W-1:0]  e2_r    [3];
  logic signed [CROSS_W-1:0] cross_r [3];
  logic                      neg_r   [3];
  logic [MAG_W-1:0]          mag_r   [3];
  logic [SUM_W-1:0]          s_r;
  logic [REM_W-1:0]          rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [CS_W-1:0]           drem_r;
  logic [CS_W-1:0]           dsh_r;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic [1:0]                part_d_r;
  logic signed [NRM_W-1:0]   nrm_r   [3];
  logic                      deg_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [NRM_W-1:0]   out_nx_r, out_ny_r, out_nz_r;
  logic                      out_deg_r;

  logic                      in_acc;
  tnu_mode_t                 in_mode;
  logic [31:0]               slot_ext;
  logic                      vslot_ok, tslot_ok;
  logic [31:0]               vidx_ext;
  logic                      vidx_oob;
  logic                      out_load;
  logic                      cross_zero;

  tnu_store_req_t            sreq;
  logic [3*COORD_W-1:0]      vtx_rdata;
  logic [3*IDX_W-1:0]        tri_rdata;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [1:0]                sq_comp, sq_part, mag_pick;
  logic [MAG_W-1:0]          mag_sel;

  logic [CS_W-1:0]           cs_a, cs_b, cs_diff;
  logic                      cs_ge;
  logic [REM_W-1:0]          rem_sh;
  logic [ROOT_W+1:0]         trial;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_mode     = tnu_mode_t'(in_ch.mode);
  assign slot_ext    = 32'(in_ch.slot);
  assign vslot_ok    = slot_ext < 32'(VERTEX_COUNT);
  assign tslot_ok    = slot_ext < 32'(TRIANGLE_COUNT);

  // vertex index under read this cycle
  assign vidx_ext = 32'(idx_r[cnt_r[1:0]]);
  assign vidx_oob = vidx_ext >= 32'(VERTEX_COUNT);

  // store requests: writes straight from the accepted item, reads by state
  always_comb begin
    sreq           = '0;
    sreq.vtx_we    = in_acc && (in_mode == MODE_WR_VTX) && vslot_ok;
    sreq.vtx_waddr = slot_ext[VADDR_W-1:0];
    sreq.vtx_wdata = {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
    sreq.tri_we    = in_acc && (in_mode == MODE_WR_TRI) && tslot_ok;
    sreq.tri_waddr = slot_ext[TADDR_W-1:0];
    sreq.tri_wdata = {in_ch.vert_c, in_ch.vert_b, in_ch.vert_a};
    sreq.tri_raddr = slot_ext[TADDR_W-1:0];
    sreq.vtx_raddr = vidx_ext[VADDR_W-1:0];
  end

  tnu_store u_store (
    .clk       (clk),
    .req       (sreq),
    .vtx_rdata (vtx_rdata),
    .tri_rdata (tri_rdata)
  );

  // square schedule: three partial products per component
  always_comb begin
    case (cnt_r)
      CNT_W'(0): begin sq_comp = 2'd0; sq_part = 2'd0; end
      CNT_W'(1): begin sq_comp = 2'd0; sq_part = 2'd1; end
      CNT_W'(2): begin sq_comp = 2'd0; sq_part = 2'd2; end
      CNT_W'(3): begin sq_comp = 2'd1; sq_part = 2'd0; end
      CNT_W'(4): begin sq_comp = 2'd1; sq_part = 2'd1; end
      CNT_W'(5): begin sq_comp = 2'd1; sq_part = 2'd2; end
      CNT_W'(6): begin sq_comp = 2'd2; sq_part = 2'd0; end
      CNT_W'(7): begin sq_comp = 2'd2; sq_part = 2'd1; end
      CNT_W'(8): begin sq_comp = 2'd2; sq_part = 2'd2; end
      default:   begin sq_comp = 2'd0; sq_part = 2'd0; end
    endcase
  end

  assign mag_pick = (state_r == S_SQ) ? sq_comp : comp_r;
  assign mag_sel  = mag_r[mag_pick];

  // multiplier operands: cross terms, then square partial products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_CROSS) begin
      case (cnt_r)
        CNT_W'(0): begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
        CNT_W'(1): begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
        CNT_W'(2): begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
        CNT_W'(3): begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
        CNT_W'(4): begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
        CNT_W'(5): begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
        default:   begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_SQ) begin
      case (sq_part)
        2'd0: begin
          mul_a = $signed(MUL_W'(mag_sel[LO_W-1:0]));
          mul_b = $signed(MUL_W'(mag_sel[LO_W-1:0]));
        end
        2'd1: begin
          mul_a = $signed(MUL_W'(mag_sel[LO_W-1:0]));
          mul_b = $signed(MUL_W'(mag_sel[MAG_W-1:LO_W]));
        end
        default: begin
          mul_a = $signed(MUL_W'(mag_sel[MAG_W-1:LO_W]));
          mul_b = $signed(MUL_W'(mag_sel[MAG_W-1:LO_W]));
        end
      endcase
    end
  end

  tnu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // compare-subtract operands: root bit pairs, then quotient bits
  assign rem_sh = {rem_r[REM_W-3:0], s_r[SUM_W-1:SUM_W-2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    cs_a = '0;
    cs_b = '0;
    if (state_r == S_SQRT) begin
      cs_a = CS_W'(rem_sh);
      cs_b = CS_W'(trial);
    end else if (state_r == S_DIV) begin
      cs_a = drem_r;
      cs_b = dsh_r;
    end
  end

  tnu_csub u_csub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign q_nxt      = {q_r[Q_W-2:0], cs_ge};
  assign cross_zero = (cross_r[0] == '0) && (cross_r[1] == '0) && (cross_r[2] == '0);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    comp_nxt  = comp_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          if (in_mode == MODE_VTX_NRM) begin
            state_nxt = S_VRD;
          end else if (in_mode == MODE_TRI_NRM) begin
            state_nxt = tslot_ok ? S_TRI : S_DONE;
          end
        end
      end
      S_TRI: begin
        state_nxt = S_VRD;
        cnt_nxt   = '0;
      end
      S_VRD: begin
        if (cnt_r == VRD_LAST) begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        state_nxt = S_CROSS;
        cnt_nxt   = '0;
      end
      S_CROSS: begin
        if (cnt_r == CROSS_LAST) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        state_nxt = cross_zero ? S_DONE : S_SQ;
        cnt_nxt   = '0;
      end
      S_SQ: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = S_SQRT;
          cnt_nxt   = '0;
        end
      end
      S_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_DLOAD;
          comp_nxt  = 2'd0;
        end
      end
      S_DLOAD: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = (comp_r == 2'd2) ? S_DONE : S_DLOAD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        // start a normal: take the indices given, clear the result
        idx_r[0] <= in_ch.vert_a;
        idx_r[1] <= in_ch.vert_b;
        idx_r[2] <= in_ch.vert_c;
        deg_r    <= !tslot_ok;
        for (int k = 0; k < 3; k++) begin
          nrm_r[k] <= '0;
        end
      end
      S_TRI: begin
        idx_r[0] <= tri_rdata[IDX_W-1:0];
        idx_r[1] <= tri_rdata[2*IDX_W-1:IDX_W];
        idx_r[2] <= tri_rdata[3*IDX_W-1:2*IDX_W];
      end
      S_VRD: begin
        // issue one vertex a cycle, capture it the cycle after
        oob_d_r <= vidx_oob;
        if (cnt_r != '0) begin
          for (int k = 0; k < 3; k++) begin
            pt_r[2'(cnt_r - CNT_W'(1))][k] <=
              oob_d_r ? '0 : vtx_rdata[k*COORD_W +: COORD_W];
          end
        end
      end
      S_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= EDGE_W'(pt_r[1][k]) - EDGE_W'(pt_r[0][k]);
          e2_r[k] <= EDGE_W'(pt_r[2][k]) - EDGE_W'(pt_r[0][k]);
        end
      end
      S_CROSS: begin
        case (cnt_r)
          CNT_W'(1): cross_r[0] <= mul_p[CROSS_W-1:0];
          CNT_W'(2): cross_r[0] <= cross_r[0] - mul_p[CROSS_W-1:0];
          CNT_W'(3): cross_r[1] <= mul_p[CROSS_W-1:0];
          CNT_W'(4): cross_r[1] <= cross_r[1] - mul_p[CROSS_W-1:0];
          CNT_W'(5): cross_r[2] <= mul_p[CROSS_W-1:0];
          CNT_W'(6): cross_r[2] <= cross_r[2] - mul_p[CROSS_W-1:0];
          default: ;
        endcase
      end
      S_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= cross_r[k][CROSS_W-1];
          mag_r[k] <= cross_r[k][CROSS_W-1] ? MAG_W'(-cross_r[k]) : MAG_W'(cross_r[k]);
        end
        deg_r  <= cross_zero;
        s_r    <= '0;
        rem_r  <= '0;
        root_r <= '0;
      end
      S_SQ: begin
        // accumulate lo^2, 2*lo*hi << 34 and hi^2 << 68
        part_d_r <= sq_part;
        if (cnt_r != '0) begin
          case (part_d_r)
            2'd0:    s_r <= s_r + SUM_W'(mul_p[2*LO_W-1:0]);
            2'd1:    s_r <= s_r + SUM_W'({mul_p[2*LO_W-1:0], {(LO_W+1){1'b0}}});
            default: s_r <= s_r + {mul_p[SUM_W-2*LO_W-1:0], {(2*LO_W){1'b0}}};
          endcase
        end
      end
      S_SQRT: begin
        // one root bit a cycle from the next radicand bit pair
        s_r <= {s_r[SUM_W-3:0], 2'b00};
        if (cs_ge) begin
          rem_r  <= cs_diff[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      S_DLOAD: begin
        // numerator 2048*|c| + L, divisor 2L aligned to the top quotient bit
        drem_r <= CS_W'({mag_sel, 11'b0}) + CS_W'(root_r);
        dsh_r  <= CS_W'({root_r, 11'b0});
        q_r    <= '0;
      end
      S_DIV: begin
        if (cs_ge) begin
          drem_r <= cs_diff;
        end
        dsh_r <= {1'b0, dsh_r[CS_W-1:1]};
        q_r   <= q_nxt;
        if (cnt_r == DIV_LAST) begin
          nrm_r[comp_r] <= neg_r[comp_r] ? -NRM_W'(q_nxt) : NRM_W'(q_nxt);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_nx_r  <= nrm_r[0];
      out_ny_r  <= nrm_r[1];
      out_nz_r  <= nrm_r[2];
      out_deg_r <= deg_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.normal_x   = out_nx_r;
  assign out_ch.normal_y   = out_ny_r;
  assign out_ch.normal_z   = out_nz_r;
  assign out_ch.degenerate = out_deg_r;

  // a quotient never exceeds one in 1.10
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DIV_LAST) |-> (q_nxt <= Q_W'(1024)))
    else $error("quotient above 1024");

  // a degenerate result carries a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |-> (out_nx_r == '0 && out_ny_r == '0 && out_nz_r == '0))
    else $error("degenerate result with non-zero normal");

  // a proper normal has length near 1024, so some component is non-zero
  a_nrm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_deg_r) |-> (out_nx_r != '0 || out_ny_r != '0 || out_nz_r != '0))
    else $error("non-degenerate result with zero normal");

  // stores are written only while the sequencer is idle
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (sreq.vtx_we || sreq.tri_we) |-> (state_r == S_IDLE))
    else $error("store write outside idle");

endmodule
`default_nettype wire

// ===== rtl/core/tnu_store.sv =====
// Vertex and triangle memories, one row per entry, registered read.
`default_nettype none
module tnu_store (
  input  logic                                  clk,
  input  tnu_pkg::tnu_store_req_t               req,
  output logic [3*tnu_pkg::COORD_W-1:0]         vtx_rdata,
  output logic [3*tnu_pkg::IDX_W-1:0]           tri_rdata
);
  import tnu_pkg::*;

  logic [3*COORD_W-1:0] vmem [VERTEX_COUNT];
  logic [3*IDX_W-1:0]   tmem [TRIANGLE_COUNT];

  always_ff @(posedge clk) begin
    if (req.vtx_we) begin
      vmem[req.vtx_waddr] <= req.vtx_wdata;
    end
    vtx_rdata <= vmem[req.vtx_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.tri_we) begin
      tmem[req.tri_waddr] <= req.tri_wdata;
    end
    tri_rdata <= tmem[req.tri_raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/tnu_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module tnu_mul (
  input  logic                                clk,
  input  logic signed [tnu_pkg::MUL_W-1:0]    a,
  input  logic signed [tnu_pkg::MUL_W-1:0]    b,
  output logic signed [tnu_pkg::PROD_W-1:0]   p_r
);
  import tnu_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tnu_csub.sv =====
// Shared compare and subtract unit for the root and quotient recurrences.
`default_nettype none
module tnu_csub (
  input  logic [tnu_pkg::CS_W-1:0] a,
  input  logic [tnu_pkg::CS_W-1:0] b,
  output logic                     ge,
  output logic [tnu_pkg::CS_W-1:0] diff
);
  import tnu_pkg::*;

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule
`default_nettype wire

// ===== tb/triangle_normal_unit_core_tb.sv =====
// Self-checking testbench of the triangle normal unit: store writes and face normals.
`default_nettype none
module triangle_normal_unit_core_tb;
  import tnu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int RAND_ITEMS   = 1130;
  localparam int TAIL_CYCLES  = 400;
  localparam int RX_HOLD      = 3000;

  typedef struct {
    tnu_mode_t        mode;
    logic [9:0]       slot;
    logic [31:0]      cx, cy, cz;
    logic [9:0]       va, vb, vc;
    bit               drain_first; // hold until every normal has come back
  } mesh_item_t;

  typedef struct {
    logic [11:0] nx, ny, nz;
    logic        degen;
  } normal_t;

  logic clk;
  logic rst_n;

  tnu_in_if  in_ch ();
  tnu_out_if out_ch ();

  triangle_normal_unit_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Pending items in issue order, and normals still owed by the block.
  mesh_item_t pend_q[$];
  normal_t    nrm_exp_q[$];

  // Shadow copy of the stores, updated as items are accepted.
  logic signed [31:0] vtx_shadow [VERTEX_COUNT][3];
  logic [9:0]         tri_shadow [TRIANGLE_COUNT][3];

  // Slots already written by generated items; reads only ever target these.
  bit         vtx_used [VERTEX_COUNT];
  bit         tri_used [TRIANGLE_COUNT];
  logic [9:0] vtx_list[$];
  logic [9:0] tri_list[$];

  int  cycle_cnt;
  int  err_cnt;
  int  res_cnt;
  bit  took_in;
  int  tx_gap;
  int  rx_gap;
  int  rx_hold_left;
  bit  rx_hold_done;

  // Clock; the single reset pulse comes from the stimulus block.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unit normal of the triangle a, b, c from the shadow vertex store.
  function automatic normal_t face_normal_calc(logic [9:0] ia, logic [9:0] ib, logic [9:0] ic);
    logic signed [159:0] e1 [3];
    logic signed [159:0] e2 [3];
    logic signed [159:0] crs [3];
    logic [159:0]        sq, root, trial, mag, num, q;
    normal_t             r;
    for (int k = 0; k < 3; k++) begin
      e1[k] = 160'(vtx_shadow[ib][k]) - 160'(vtx_shadow[ia][k]);
      e2[k] = 160'(vtx_shadow[ic][k]) - 160'(vtx_shadow[ia][k]);
    end
    crs[0] = e1[1] * e2[2] - e1[2] * e2[1];
    crs[1] = e1[2] * e2[0] - e1[0] * e2[2];
    crs[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sq = crs[0] * crs[0] + crs[1] * crs[1] + crs[2] * crs[2];
    if (sq == '0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
      return r;
    end
    // Floor square root, one bit at a time; the root stays below 2^67.
    root = '0;
    for (int b = 66; b >= 0; b--) begin
      trial = root | (160'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    r.degen = 1'b0;
    for (int k = 0; k < 3; k++) begin
      mag = crs[k][159] ? -crs[k] : crs[k];
      // Round to nearest, ties away from zero.
      num = mag * 160'd2048 + root;
      q   = num / (root + root);
      if (k == 0) r.nx = crs[k][159] ? -q[11:0] : q[11:0];
      if (k == 1) r.ny = crs[k][159] ? -q[11:0] : q[11:0];
      if (k == 2) r.nz = crs[k][159] ? -q[11:0] : q[11:0];
    end
    return r;
  endfunction

  // Item with random content in every field, the mode aside.
  function automatic mesh_item_t noise_item(tnu_mode_t m);
    mesh_item_t it;
    it.mode = m;
    it.slot = 10'($urandom);
    it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
    it.va = 10'($urandom); it.vb = 10'($urandom); it.vc = 10'($urandom);
    it.drain_first = 1'b0;
    return it;
  endfunction

  function automatic logic [9:0] pick_vtx();
    return vtx_list[$urandom_range(0, vtx_list.size() - 1)];
  endfunction

  task automatic add_vtx(logic [9:0] s, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    mesh_item_t it;
    it = noise_item(MODE_WR_VTX);
    it.slot = s; it.cx = x; it.cy = y; it.cz = z;
    if (!vtx_used[s]) begin
      vtx_used[s] = 1'b1;
      vtx_list.push_back(s);
    end
    pend_q.push_back(it);
  endtask

  task automatic add_tri(logic [9:0] s, logic [9:0] a, logic [9:0] b, logic [9:0] c);
    mesh_item_t it;
    it = noise_item(MODE_WR_TRI);
    it.slot = s; it.va = a; it.vb = b; it.vc = c;
    if (!tri_used[s]) begin
      tri_used[s] = 1'b1;
      tri_list.push_back(s);
    end
    pend_q.push_back(it);
  endtask

  task automatic add_tri_nrm(logic [9:0] s);
    mesh_item_t it;
    it = noise_item(MODE_TRI_NRM);
    it.slot = s;
    pend_q.push_back(it);
  endtask

  task automatic add_vtx_nrm(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    mesh_item_t it;
    it = noise_item(MODE_VTX_NRM);
    it.va = a; it.vb = b; it.vc = c;
    pend_q.push_back(it);
  endtask

  // Mostly no gap, some short ones, a few long; run flat out while bit 9 of the cycle count is set.
  function automatic int pick_gap();
    int r;
    if (cycle_cnt[9]) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 8191)) - 4096);
    if (r == 8) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    return 32'($signed($urandom_range(0, 4)) - 2);
  endfunction

  // Stimulus: directed corners first, then a random mix weighted towards normals.
  initial begin
    int r;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = '0;
    in_ch.slot    = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.vert_a  = '0;
    in_ch.vert_b  = '0;
    in_ch.vert_c  = '0;
    out_ch.ready  = 1'b0;

    // Extreme coordinates give the largest cross product.
    add_vtx(10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vtx(10'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_vtx(10'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    // Collinear points.
    add_vtx(10'd3, 32'd0, 32'd0, 32'd0);
    add_vtx(10'd4, 32'd1, 32'd1, 32'd1);
    add_vtx(10'd5, 32'd2, 32'd2, 32'd2);
    // Unit axes: normal exactly one along z.
    add_vtx(10'd6, 32'd1024, 32'd0, 32'd0);
    add_vtx(10'd7, 32'd0, 32'd1024, 32'd0);
    add_vtx(10'd1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_vtx_nrm(10'd0, 10'd1, 10'd2);
    add_vtx_nrm(10'd3, 10'd6, 10'd7);
    add_vtx_nrm(10'd3, 10'd7, 10'd6);
    add_vtx_nrm(10'd3, 10'd4, 10'd5);      // collinear
    add_vtx_nrm(10'd4, 10'd4, 10'd4);      // coincident
    add_vtx_nrm(10'd1023, 10'd0, 10'd1023); // two corners the same
    add_vtx_nrm(10'd1023, 10'd2, 10'd1);
    add_tri(10'd0, 10'd0, 10'd1, 10'd2);
    add_tri(10'd1023, 10'd3, 10'd6, 10'd7);
    add_tri(10'd512, 10'd3, 10'd4, 10'd5);
    add_tri_nrm(10'd0);
    add_tri_nrm(10'd1023);
    add_tri_nrm(10'd512);
    add_tri(10'd0, 10'd1023, 10'd1, 10'd0); // overwrite a stored triangle
    add_tri_nrm(10'd0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_vtx(10'($urandom), rand_coord(), rand_coord(), rand_coord());
      end else if (r < 42) begin
        add_tri(10'($urandom), pick_vtx(), pick_vtx(), pick_vtx());
      end else if (r < 66) begin
        add_tri_nrm(tri_list[$urandom_range(0, tri_list.size() - 1)]);
      end else if (r < 96) begin
        add_vtx_nrm(pick_vtx(), pick_vtx(), pick_vtx());
      end else begin
        // Repeated corner: always degenerate.
        add_vtx_nrm(pick_vtx(), vtx_list[0], vtx_list[0]);
      end
      if (i == RAND_ITEMS / 2) pend_q[$].drain_first = 1'b1;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the queue to empty and the block to go quiet.
    do @(posedge clk);
    while (pend_q.size() != 0 || in_ch.valid || nrm_exp_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (nrm_exp_q.size() != 0) begin
      $display("%0t: %0d normals never arrived", $time, nrm_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d items pending, %0d normals owed",
               $time, pend_q.size(), nrm_exp_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cycle_cnt    = 0;
    err_cnt      = 0;
    res_cnt      = 0;
    took_in      = 1'b0;
    tx_gap       = 0;
    rx_gap       = 0;
    rx_hold_left = 0;
    rx_hold_done = 1'b0;
  end

  // Sender: advance on an accepted item, hold the current one otherwise.
  always @(negedge clk) begin
    mesh_item_t it;
    logic       nxt_valid;
    nxt_valid = in_ch.valid;
    if (rst_n && (took_in || !in_ch.valid)) begin
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pend_q.size() != 0 &&
                   !(pend_q[0].drain_first && nrm_exp_q.size() != 0)) begin
        it = pend_q.pop_front();
        in_ch.mode    <= it.mode;
        in_ch.slot    <= it.slot;
        in_ch.coord_x <= it.cx;
        in_ch.coord_y <= it.cy;
        in_ch.coord_z <= it.cz;
        in_ch.vert_a  <= it.va;
        in_ch.vert_b  <= it.vb;
        in_ch.vert_c  <= it.vc;
        nxt_valid = 1'b1;
        tx_gap = pick_gap();
      end
    end
    in_ch.valid <= nxt_valid;
  end

  // Receiver: random stalls, plus one long hold-off to fill the block.
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
    end else if (!rx_hold_done && res_cnt >= 60) begin
      rx_hold_done = 1'b1;
      rx_hold_left = RX_HOLD;
    end else if (rx_gap > 0) begin
      rx_gap--;
    end else begin
      nxt_ready = 1'b1;
      rx_gap = pick_gap();
    end
    out_ch.ready <= nxt_ready;
  end

  // Accepted input items: update the shadow stores and predict normals.
  always @(posedge clk) begin
    logic [9:0] s;
    normal_t    n;
    took_in <= in_ch.valid && in_ch.ready && rst_n;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s = in_ch.slot;
      case (tnu_mode_t'(in_ch.mode))
        MODE_WR_VTX: begin
          vtx_shadow[s][0] = in_ch.coord_x;
          vtx_shadow[s][1] = in_ch.coord_y;
          vtx_shadow[s][2] = in_ch.coord_z;
        end
        MODE_WR_TRI: begin
          tri_shadow[s][0] = in_ch.vert_a;
          tri_shadow[s][1] = in_ch.vert_b;
          tri_shadow[s][2] = in_ch.vert_c;
        end
        MODE_TRI_NRM: begin
          n = face_normal_calc(tri_shadow[s][0], tri_shadow[s][1], tri_shadow[s][2]);
          nrm_exp_q.push_back(n);
        end
        default: begin
          n = face_normal_calc(in_ch.vert_a, in_ch.vert_b, in_ch.vert_c);
          nrm_exp_q.push_back(n);
        end
      endcase
    end
  end

  // Accepted result items: compare with the oldest prediction.
  always @(posedge clk) begin
    normal_t n;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_cnt <= res_cnt + 1;
      if (nrm_exp_q.size() == 0) begin
        $display("%0t: unexpected normal (%0d %0d %0d) degen %0b", $time,
                 $signed(out_ch.normal_x), $signed(out_ch.normal_y),
                 $signed(out_ch.normal_z), out_ch.degenerate);
        err_cnt++;
      end else begin
        n = nrm_exp_q.pop_front();
        if (out_ch.normal_x !== n.nx || out_ch.normal_y !== n.ny ||
            out_ch.normal_z !== n.nz || out_ch.degenerate !== n.degen) begin
          $display("%0t: normal mismatch, expected (%0d %0d %0d) degen %0b, got (%0d %0d %0d) degen %0b",
                   $time, $signed(n.nx), $signed(n.ny), $signed(n.nz), n.degen,
                   $signed(out_ch.normal_x), $signed(out_ch.normal_y),
                   $signed(out_ch.normal_z), out_ch.degenerate);
          err_cnt++;
        end
      end
    end
  end

endmodule
`default_nettype wire
